@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the sequence store.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSQ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("bsq assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BSQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("bsq assertion failed");

`endif

@@ design/bsq_pkg.sv @@
// Package for the bounded sequence store: field widths, opcodes, status codes
// and sequencer states. No dependencies.
`default_nettype none

package bsq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 10;
    localparam int ENTRIES_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_PUSH     = 3'd1,
        OP_POP      = 3'd2,
        OP_READ     = 3'd3,
        OP_DELETE   = 3'd4,
        OP_CONTAINS = 3'd5,
        OP_CLEAR    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MEM  = 2'd1,
        S_RESP = 2'd2
    } state_t;

endpackage

`default_nettype wire

@@ design/bsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/bsq_addr_unit.sv @@
// Shared address unit: base plus offset, wrapped into the ring of DEPTH slots.
// No dependencies.
`default_nettype none

module bsq_addr_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic [$clog2(DEPTH)-1:0] base,
    input  wire logic [$clog2(DEPTH)-1:0] offset,
    output logic      [$clog2(DEPTH)-1:0] addr
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] RING = (AW+1)'(DEPTH);

    logic [AW:0] sum;

    // one add and one compare-subtract; both operands are below DEPTH
    always_comb
    begin
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= RING)
        begin
            addr = AW'(sum - RING);
        end
        else
        begin
            addr = sum[AW-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/bounded_sequence_store.sv @@
// Bounded sequence store top level: sequencer, ring pointers and response register.
// Depends on bsq_pkg, bsq_ram and bsq_addr_unit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------
//  request   | req_valid / req_ready  | op, value, position
//  response  | rsp_valid / rsp_ready  | data, found, status, entries
//
// Append, push, clear and failed requests go from idle straight to the response
// state. Read and pop read one entry in the memory state, delete walks from the
// position to the last entry, and contains walks the store, one stored entry per
// cycle, stopping at the first match; each uses the single RAM read port and one
// address unit. Reset clears state, count, head and flags; storage is not cleared.
// req_ready is high only while idle; a stalled response holds in its register.
`default_nettype none

module bounded_sequence_store
    import bsq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic        [OP_W-1:0]      op,
    input  wire logic signed [DATA_W-1:0]    value,
    input  wire logic        [POS_W-1:0]     position,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic signed      [DATA_W-1:0]    data,
    output logic                             found,
    output logic             [1:0]           status,
    output logic             [ENTRIES_W-1:0] entries
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    state_t                  state_reg,     state_next;
    op_t                     op_reg,        op_next;
    logic signed [DATA_W-1:0] value_reg,    value_next;
    logic [AW-1:0]           head_reg,      head_next;
    logic [CW-1:0]           fill_reg,      fill_next;
    logic [CW-1:0]           ridx_reg,      ridx_next;
    logic [CW-1:0]           lim_reg,       lim_next;
    logic                    pend_reg,      pend_next;
    logic                    first_reg,     first_next;
    logic [AW-1:0]           rphys1_reg,    rphys1_next;
    logic [AW-1:0]           rphys2_reg,    rphys2_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic                    res_found_reg, res_found_next;
    status_t                 res_status_reg, res_status_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W-1:0] data_reg,     data_next;
    logic                    found_reg,     found_next;
    status_t                 status_reg,    status_next;
    logic [ENTRIES_W-1:0]    entries_reg,   entries_next;

    logic [AW-1:0]           unit_off;
    logic [AW-1:0]           unit_addr;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [DATA_W-1:0]       ram_rdata;
    logic [XW-1:0]           pos_ext;
    logic [XW-1:0]           fill_ext;
    logic                    is_full;
    logic                    hit;
    logic                    issue;

    // storage ring
    bsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (unit_addr),
        .rdata (ram_rdata)
    );

    // shared logical-to-physical address unit
    bsq_addr_unit #(
        .DEPTH (DEPTH)
    ) u_addr (
        .base   (head_reg),
        .offset (unit_off),
        .addr   (unit_addr)
    );

    assign pos_ext  = XW'(position);
    assign fill_ext = XW'(fill_reg);
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign hit      = pend_reg && (op_reg == OP_CONTAINS) && (ram_rdata == value_reg);
    assign issue    = (ridx_reg < lim_reg) && !hit;

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        ridx_reg       <= ridx_next;
        lim_reg        <= lim_next;
        rphys1_reg     <= rphys1_next;
        rphys2_reg     <= rphys2_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        data_reg       <= data_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        entries_reg    <= entries_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        ridx_next       = ridx_reg;
        lim_next        = lim_reg;
        pend_next       = pend_reg;
        first_next      = first_reg;
        rphys1_next     = rphys1_reg;
        rphys2_next     = rphys2_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        data_next       = data_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        entries_next    = entries_reg;
        unit_off        = '0;
        ram_we          = 1'b0;
        ram_waddr       = unit_addr;
        ram_wdata       = value;

        // response register drains independently
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = op_t'(op);
                    value_next      = value;
                    res_data_next   = '0;
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                    pend_next       = 1'b0;
                    first_next      = 1'b0;
                    state_next      = S_RESP;
                    case (op_t'(op))
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                unit_off  = fill_reg[AW-1:0];
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                unit_off  = AW'(DEPTH - 1);
                                ram_we    = 1'b1;
                                head_next = unit_addr;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ridx_next  = '0;
                                lim_next   = CW'(1);
                                first_next = 1'b1;
                                state_next = S_MEM;
                            end
                        end
                        OP_READ,
                        OP_DELETE:
                        begin
                            if (pos_ext >= fill_ext)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ridx_next  = pos_ext[CW-1:0];
                                lim_next   = (op_t'(op) == OP_READ) ?
                                             pos_ext[CW-1:0] + 1'b1 : fill_reg;
                                first_next = 1'b1;
                                state_next = S_MEM;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            ridx_next  = '0;
                            lim_next   = fill_reg;
                            state_next = S_MEM;
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                            head_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_MEM:
            begin
                // consume the entry read in the previous cycle
                if (pend_reg)
                begin
                    if (op_reg == OP_CONTAINS)
                    begin
                        if (hit)
                        begin
                            res_found_next = 1'b1;
                        end
                    end
                    else if (first_reg)
                    begin
                        res_data_next = ram_rdata;
                        first_next    = 1'b0;
                    end
                    else
                    begin
                        // delete: close up one slot
                        ram_we    = 1'b1;
                        ram_waddr = rphys2_reg;
                        ram_wdata = ram_rdata;
                    end
                end

                if (issue)
                begin
                    unit_off    = ridx_reg[AW-1:0];
                    ridx_next   = ridx_reg + 1'b1;
                    rphys1_next = unit_addr;
                    rphys2_next = rphys1_reg;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                    if (op_reg == OP_DELETE)
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                    else if (op_reg == OP_POP)
                    begin
                        unit_off  = AW'(1);
                        head_next = unit_addr;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = res_data_reg;
                    found_next     = res_found_reg;
                    status_next    = res_status_reg;
                    entries_next   = ENTRIES_W'(fill_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign entries   = entries_reg;

endmodule

`default_nettype wire

@@ design/bsq_checker.sv @@
// Port-level checker for the bounded sequence store, bound to the top level.
// Depends on bsq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsq_checker
    import bsq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic signed [DATA_W-1:0]    data,
    input wire logic                        found,
    input wire logic        [1:0]           status,
    input wire logic        [ENTRIES_W-1:0] entries
);

    // a stalled response stays offered
    `BSQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // one request at a time: ready drops right after a request is taken
    `BSQ_ASSERT_NEXT(a_one_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // full only when the store is at capacity, with no data
    `BSQ_ASSERT_IMPL(a_full, clk, rst_n, rsp_valid && (status == ST_FULL),
                     (entries == ENTRIES_W'(DEPTH)) && (data == '0) && !found)

    // empty pop reports an empty store and no data
    `BSQ_ASSERT_IMPL(a_empty, clk, rst_n, rsp_valid && (status == ST_EMPTY),
                     (entries == '0) && (data == '0) && !found)

    // a found value is only reported on a successful request
    `BSQ_ASSERT_IMPL(a_found_ok, clk, rst_n, rsp_valid && found,
                     (status == ST_OK) && (data == '0) && (entries != '0))

endmodule

bind bounded_sequence_store bsq_checker #(
    .DEPTH (DEPTH)
) u_bsq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .data      (data),
    .found     (found),
    .status    (status),
    .entries   (entries)
);

`default_nettype wire
